@@ rtl/ahfr_pkg.sv @@
package ahfr_pkg;

   localparam logic [7:0] CHAR_S  = 8'h53;
   localparam logic [7:0] CHAR_T  = 8'h54;
   localparam logic [7:0] CHAR_K  = 8'h4B;
   localparam logic [7:0] CHAR_X  = 8'h58;
   localparam logic [7:0] CHAR_Q  = 8'h71;
   localparam logic [7:0] CHAR_0  = 8'h30;
   localparam logic [7:0] CHAR_9  = 8'h39;
   localparam logic [7:0] CHAR_UA = 8'h41;
   localparam logic [7:0] CHAR_UF = 8'h46;
   localparam logic [7:0] CHAR_LA = 8'h61;
   localparam logic [7:0] CHAR_LF = 8'h66;
   localparam logic [7:0] CHAR_NONE = 8'h00;

   localparam logic [31:0] PROG_START_RESET = 32'h0000_1000;
   localparam logic [31:0] PROG_END_RESET   = 32'h0004_0000;

   localparam int ADDR_NIBBLES = 8;

   typedef enum logic [0:0] {
      REG_PROG_START = 1'b0,
      REG_PROG_END   = 1'b1
   } reg_idx_type;

   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_START = 3'd1,
      EV_ADDR  = 3'd2,
      EV_DATA  = 3'd3,
      EV_OK    = 3'd4,
      EV_ERR   = 3'd5,
      EV_BOOT  = 3'd6
   } ev_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_ADDR = 4'b0010,
      PH_HI   = 4'b0100,
      PH_LO   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [31:0] prog_start;
      logic [31:0] prog_end;
   } cfg_type;

   typedef struct packed {
      ev_type      event_res;
      logic [7:0]  reply_byte;
      logic [7:0]  data_byte;
      logic [9:0]  byte_index;
      logic [31:0] block_address;
      logic [10:0] block_length;
      logic        range_ok;
   } rsp_type;

endpackage

@@ rtl/ascii_hex_frame_receiver_core.sv @@
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_rx_byte
// rsp_      out        rsp_valid/rsp_stall  event, reply, data, index, address, length, range
// csr_      in         APB write/read       prog_start at 0x0, prog_end at 0x4
//
// One word is accepted per cycle while req_stall is low; its result is registered in the
// output register, or in the skid entry while that is held. The parse step is a single
// pass of decode logic on the frame state. Reset is synchronous; it idles the parser and
// empties the output stage. A two-entry output buffer keeps input flowing while one result
// waits; req_stall rises only when both entries hold words.
module ascii_hex_frame_receiver_core #(
   parameter int MAX_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_reply_byte,
   output logic [7:0]  rsp_data_byte,
   output logic [9:0]  rsp_byte_index,
   output logic [31:0] rsp_block_address,
   output logic [10:0] rsp_block_length,
   output logic        rsp_range_ok,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ahfr_pkg::cfg_type cfg;
   ahfr_pkg::rsp_type step_res;
   ahfr_pkg::rsp_type out_res;
   logic              accept;

   assign accept = req_valid && !req_stall;

   ahfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (psel),
      .csr_penable (penable),
      .csr_pwrite  (pwrite),
      .csr_paddr   (paddr),
      .csr_pwdata  (pwdata),
      .csr_prdata  (prdata),
      .csr_pready  (pready),
      .cfg         (cfg)
   );

   ahfr_parser #(
      .MAX_BYTES (MAX_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .res     (step_res)
   );

   ahfr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (step_res),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_res)
   );

   assign rsp_event_res     = out_res.event_res;
   assign rsp_reply_byte    = out_res.reply_byte;
   assign rsp_data_byte     = out_res.data_byte;
   assign rsp_byte_index    = out_res.byte_index;
   assign rsp_block_address = out_res.block_address;
   assign rsp_block_length  = out_res.block_length;
   assign rsp_range_ok      = out_res.range_ok;

endmodule

@@ rtl/ahfr_csr.sv @@
module ahfr_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output ahfr_pkg::cfg_type    cfg
);

   logic [31:0] prog_start_ff, prog_start_in;
   logic [31:0] prog_end_ff, prog_end_in;
   logic        wr_en;
   ahfr_pkg::reg_idx_type idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx = ahfr_pkg::reg_idx_type'(csr_paddr[2]);

   always_comb begin
      prog_start_in = prog_start_ff;
      prog_end_in   = prog_end_ff;
      if (wr_en) begin
         unique case (idx)
            ahfr_pkg::REG_PROG_START: prog_start_in = csr_pwdata;
            ahfr_pkg::REG_PROG_END:   prog_end_in   = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         ahfr_pkg::REG_PROG_START: csr_prdata = prog_start_ff;
         ahfr_pkg::REG_PROG_END:   csr_prdata = prog_end_ff;
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_start_ff <= ahfr_pkg::PROG_START_RESET;
         prog_end_ff   <= ahfr_pkg::PROG_END_RESET;
      end else begin
         prog_start_ff <= prog_start_in;
         prog_end_ff   <= prog_end_in;
      end
   end

   assign cfg.prog_start = prog_start_ff;
   assign cfg.prog_end   = prog_end_ff;

endmodule

@@ rtl/ahfr_parser.sv @@
module ahfr_parser #(
   parameter int MAX_BYTES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  ahfr_pkg::cfg_type    cfg,
   output ahfr_pkg::rsp_type    res
);

   localparam int CNT_W = $clog2(MAX_BYTES + 1);
   localparam int NIB_W = $clog2(ahfr_pkg::ADDR_NIBBLES);

   ahfr_pkg::phase_type phase_ff, phase_in;
   logic [NIB_W-1:0] nib_ff, nib_in;
   logic [31:0]      addr_ff, addr_in;
   logic [3:0]       hi_ff, hi_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [3:0]  nib_val;
   logic [31:0] cnt32;
   logic [31:0] last_addr;
   logic        first_in, last_in;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'h00;
         if (c >= ahfr_pkg::CHAR_0 && c <= ahfr_pkg::CHAR_9) begin
            d = c - ahfr_pkg::CHAR_0;
         end else if (c >= ahfr_pkg::CHAR_LA && c <= ahfr_pkg::CHAR_LF) begin
            d = c - ahfr_pkg::CHAR_LA + 8'd10;
         end else if (c >= ahfr_pkg::CHAR_UA && c <= ahfr_pkg::CHAR_UF) begin
            d = c - ahfr_pkg::CHAR_UA + 8'd10;
         end
         hex_value = d[3:0];
      end
   endfunction

   assign nib_val   = hex_value(rx_byte);
   assign cnt32     = 32'(cnt_ff);
   assign last_addr = addr_ff + cnt32 - 32'd1;
   assign first_in  = (addr_ff >= cfg.prog_start) && (addr_ff < cfg.prog_end);
   assign last_in   = (last_addr >= cfg.prog_start) && (last_addr < cfg.prog_end);

   always_comb begin
      phase_in = phase_ff;
      nib_in   = nib_ff;
      addr_in  = addr_ff;
      hi_in    = hi_ff;
      cnt_in   = cnt_ff;
      res      = '0;
      res.event_res = ahfr_pkg::EV_NONE;
      if (accept) begin
         unique case (phase_ff)
            ahfr_pkg::PH_ADDR: begin
               if (rx_byte == ahfr_pkg::CHAR_T) begin
                  phase_in       = ahfr_pkg::PH_IDLE;
                  res.event_res  = ahfr_pkg::EV_ERR;
                  res.reply_byte = ahfr_pkg::CHAR_X;
               end else begin
                  addr_in = {addr_ff[27:0], nib_val};
                  nib_in  = nib_ff + 1'b1;
                  if (nib_ff == NIB_W'(ahfr_pkg::ADDR_NIBBLES - 1)) begin
                     phase_in          = ahfr_pkg::PH_HI;
                     res.event_res     = ahfr_pkg::EV_ADDR;
                     res.block_address = {addr_ff[27:0], nib_val};
                  end
               end
            end
            ahfr_pkg::PH_HI: begin
               if (rx_byte == ahfr_pkg::CHAR_T) begin
                  phase_in          = ahfr_pkg::PH_IDLE;
                  res.event_res     = ahfr_pkg::EV_OK;
                  res.reply_byte    = ahfr_pkg::CHAR_K;
                  res.block_address = addr_ff;
                  res.block_length  = cnt32[10:0];
                  res.range_ok      = first_in && last_in;
               end else begin
                  hi_in    = nib_val;
                  phase_in = ahfr_pkg::PH_LO;
               end
            end
            ahfr_pkg::PH_LO: begin
               if (rx_byte == ahfr_pkg::CHAR_T || cnt_ff >= CNT_W'(MAX_BYTES)) begin
                  phase_in       = ahfr_pkg::PH_IDLE;
                  res.event_res  = ahfr_pkg::EV_ERR;
                  res.reply_byte = ahfr_pkg::CHAR_X;
               end else begin
                  res.event_res  = ahfr_pkg::EV_DATA;
                  res.data_byte  = {hi_ff, nib_val};
                  res.byte_index = cnt32[9:0];
                  cnt_in         = cnt_ff + 1'b1;
                  phase_in       = ahfr_pkg::PH_HI;
               end
            end
            default: begin
               // idle: clear the frame counters, look for start or boot
               nib_in  = '0;
               addr_in = '0;
               cnt_in  = '0;
               hi_in   = '0;
               if (rx_byte == ahfr_pkg::CHAR_S) begin
                  phase_in      = ahfr_pkg::PH_ADDR;
                  res.event_res = ahfr_pkg::EV_START;
               end else if (rx_byte == ahfr_pkg::CHAR_Q) begin
                  res.event_res = ahfr_pkg::EV_BOOT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ahfr_pkg::PH_IDLE;
         nib_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         nib_ff   <= nib_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      hi_ff   <= hi_in;
   end

endmodule

@@ rtl/ahfr_skid.sv @@
module ahfr_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ahfr_pkg::rsp_type    in_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output ahfr_pkg::rsp_type    out_data
);

   logic              out_vld_ff, out_vld_in;
   logic              skid_vld_ff, skid_vld_in;
   ahfr_pkg::rsp_type out_ff, out_in;
   ahfr_pkg::rsp_type skid_ff, skid_in;
   logic              take;

   assign take = out_vld_ff && !out_stall;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (take) begin
         out_vld_in = 1'b0;
      end
      if (skid_vld_ff) begin
         // advance the parked word once the output drains
         if (take) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_vld_ff || take) begin
            out_in     = in_data;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = in_data;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_vld_ff;
   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;

endmodule

@@ rtl/ahfr_checker.sv @@
module ahfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_res,
   input logic [7:0]  rsp_reply_byte,
   input logic        rsp_range_ok
);

   // a held result keeps its event code
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_event_res)))
      else $error("stalled result changed");

   // input backs up only behind a full output stage
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without pending result");

   a_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_event_res == ahfr_pkg::EV_OK && rsp_reply_byte == ahfr_pkg::CHAR_K) ||
          (rsp_event_res == ahfr_pkg::EV_ERR && rsp_reply_byte == ahfr_pkg::CHAR_X) ||
          (rsp_event_res != ahfr_pkg::EV_OK && rsp_event_res != ahfr_pkg::EV_ERR &&
           rsp_reply_byte == ahfr_pkg::CHAR_NONE)))
      else $error("reply byte does not match event");

   a_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_ok) |-> (rsp_event_res == ahfr_pkg::EV_OK))
      else $error("range_ok outside frame ok");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ascii_hex_frame_receiver_core ahfr_checker u_ahfr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_event_res (rsp_event_res),
   .rsp_reply_byte(rsp_reply_byte),
   .rsp_range_ok  (rsp_range_ok)
);

@@ bench/ascii_hex_frame_receiver_core_test.sv @@
`timescale 1ns / 1ps

module ascii_hex_frame_receiver_core_test;

   localparam int FRAME_CAPACITY = 1024;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int PHASE_WORDS    = 220;
   localparam logic [7:0] CHAR_UZ = 8'h5A;
   localparam logic [7:0] CHAR_LZ = 8'h7A;

   typedef enum int {FLAW_NONE, FLAW_ADDR_T, FLAW_ODD} flaw_type;

   typedef struct {
      logic [7:0]        ch;
      bit                typed;
      ahfr_pkg::rsp_type want;
   } script_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_reply_byte;
   logic [7:0]  rsp_data_byte;
   logic [9:0]  rsp_byte_index;
   logic [31:0] rsp_block_address;
   logic [10:0] rsp_block_length;
   logic        rsp_range_ok;
   logic        psel        = 1'b0;
   logic        penable     = 1'b0;
   logic        pwrite      = 1'b0;
   logic [2:0]  paddr       = 3'd0;
   logic [31:0] pwdata      = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // predictor copy of the parser state and the program region
   ahfr_pkg::phase_type rx_phase = ahfr_pkg::PH_IDLE;
   logic [3:0]  addr_nibbles = '0;
   logic [31:0] addr_acc     = '0;
   logic [3:0]  pend_nibble  = '0;
   logic [10:0] byte_total   = '0;
   logic [31:0] region_lo    = ahfr_pkg::PROG_START_RESET;
   logic [31:0] region_hi    = ahfr_pkg::PROG_END_RESET;

   ahfr_pkg::rsp_type pending_results[$];
   script_row_type    script_q[$];

   int errors       = 0;
   int words_sent   = 0;
   int results_seen = 0;
   int frames_acked = 0;
   int acked_inside = 0;
   int frames_bad   = 0;
   int boot_seen    = 0;
   int region_sets  = 0;
   int quiet_left   = 0;
   int cycle_count  = 0;
   bit flood_done   = 1'b0;

   ascii_hex_frame_receiver_core #(
      .MAX_BYTES(FRAME_CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_res(rsp_event_res),
      .rsp_reply_byte(rsp_reply_byte),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_block_address(rsp_block_address),
      .rsp_block_length(rsp_block_length),
      .rsp_range_ok(rsp_range_ok),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= ahfr_pkg::CHAR_0 && c <= ahfr_pkg::CHAR_9)
         return 4'(c - ahfr_pkg::CHAR_0);
      if (c >= ahfr_pkg::CHAR_LA && c <= ahfr_pkg::CHAR_LF)
         return 4'(c - ahfr_pkg::CHAR_LA + 8'd10);
      if (c >= ahfr_pkg::CHAR_UA && c <= ahfr_pkg::CHAR_UF)
         return 4'(c - ahfr_pkg::CHAR_UA + 8'd10);
      return 4'h0;
   endfunction

   function automatic bit in_program(input logic [31:0] a);
      return (a >= region_lo) && (a < region_hi);
   endfunction

   function automatic ahfr_pkg::rsp_type parse_char(input logic [7:0] c);
      ahfr_pkg::rsp_type r;
      logic [31:0]       last_addr;
      r = '0;
      case (rx_phase)
         ahfr_pkg::PH_IDLE: begin
            addr_nibbles = '0;
            addr_acc = '0;
            byte_total = '0;
            pend_nibble = '0;
            if (c == ahfr_pkg::CHAR_S) begin
               rx_phase = ahfr_pkg::PH_ADDR;
               r.event_res = ahfr_pkg::EV_START;
            end else if (c == ahfr_pkg::CHAR_Q) begin
               r.event_res = ahfr_pkg::EV_BOOT;
            end
         end
         ahfr_pkg::PH_ADDR: begin
            if (c == ahfr_pkg::CHAR_T) begin
               rx_phase = ahfr_pkg::PH_IDLE;
               r.event_res = ahfr_pkg::EV_ERR;
               r.reply_byte = ahfr_pkg::CHAR_X;
            end else begin
               addr_acc = {addr_acc[27:0], nibble_of(c)};
               addr_nibbles = addr_nibbles + 4'd1;
               if (addr_nibbles >= ahfr_pkg::ADDR_NIBBLES) begin
                  rx_phase = ahfr_pkg::PH_HI;
                  r.event_res = ahfr_pkg::EV_ADDR;
                  r.block_address = addr_acc;
               end
            end
         end
         ahfr_pkg::PH_HI: begin
            if (c == ahfr_pkg::CHAR_T) begin
               // an empty frame ends one byte below its start address
               last_addr = addr_acc + {21'd0, byte_total} - 32'd1;
               rx_phase = ahfr_pkg::PH_IDLE;
               r.event_res = ahfr_pkg::EV_OK;
               r.reply_byte = ahfr_pkg::CHAR_K;
               r.block_address = addr_acc;
               r.block_length = byte_total;
               r.range_ok = in_program(addr_acc) && in_program(last_addr);
            end else begin
               pend_nibble = nibble_of(c);
               rx_phase = ahfr_pkg::PH_LO;
            end
         end
         ahfr_pkg::PH_LO: begin
            if (c == ahfr_pkg::CHAR_T || byte_total >= FRAME_CAPACITY) begin
               rx_phase = ahfr_pkg::PH_IDLE;
               r.event_res = ahfr_pkg::EV_ERR;
               r.reply_byte = ahfr_pkg::CHAR_X;
            end else begin
               r.event_res = ahfr_pkg::EV_DATA;
               r.data_byte = {pend_nibble, nibble_of(c)};
               r.byte_index = byte_total[9:0];
               byte_total = byte_total + 11'd1;
               rx_phase = ahfr_pkg::PH_HI;
            end
         end
         default: rx_phase = ahfr_pkg::PH_IDLE;
      endcase
      return r;
   endfunction

   function automatic ahfr_pkg::rsp_type outcome(input ahfr_pkg::ev_type ev,
                                                 input logic [7:0] reply,
                                                 input logic [31:0] addr,
                                                 input logic [10:0] len,
                                                 input logic rok);
      ahfr_pkg::rsp_type r;
      r = '0;
      r.event_res = ev;
      r.reply_byte = reply;
      r.block_address = addr;
      r.block_length = len;
      r.range_ok = rok;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         quiet_left = $urandom_range(30, 120);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return ahfr_pkg::CHAR_0 + 8'(n);
      return ($urandom_range(0, 1) ? ahfr_pkg::CHAR_UA : ahfr_pkg::CHAR_LA)
             + 8'(n) - 8'd10;
   endfunction

   // mostly clean hex, now and then a random stray byte, with 'T' replaced by 'Z'
   function automatic logic [7:0] content_char(input logic [3:0] n);
      logic [7:0] c;
      if ($urandom_range(0, 99) < 94) return hex_char(n);
      c = 8'($urandom_range(0, 255));
      if (c == ahfr_pkg::CHAR_T) c = CHAR_UZ;
      return c;
   endfunction

   task automatic send_word(input logic [7:0] ch, input bit typed,
                            input ahfr_pkg::rsp_type want);
      int                gap;
      ahfr_pkg::rsp_type got;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= ch;
      do @(posedge clock); while (req_stall !== 1'b0);
      got = parse_char(ch);
      pending_results.push_back(typed ? want : got);
      words_sent++;
   endtask

   task automatic send_char(input logic [7:0] ch);
      send_word(ch, 1'b0, '0);
   endtask

   task automatic send_frame(input logic [31:0] base, input int len, input flaw_type flaw);
      int cut;
      cut = $urandom_range(0, ahfr_pkg::ADDR_NIBBLES - 1);
      send_char(ahfr_pkg::CHAR_S);
      for (int i = 0; i < ahfr_pkg::ADDR_NIBBLES; i++) begin
         if (flaw == FLAW_ADDR_T && i == cut) break;
         send_char(content_char(base[31 - 4*i -: 4]));
      end
      if (flaw != FLAW_ADDR_T) begin
         for (int i = 0; i < len; i++) begin
            send_char(content_char(4'($urandom_range(0, 15))));
            send_char(content_char(4'($urandom_range(0, 15))));
         end
         if (flaw == FLAW_ODD) send_char(content_char(4'($urandom_range(0, 15))));
      end
      send_char(ahfr_pkg::CHAR_T);
   endtask

   task automatic send_random_frame();
      int          len, r;
      flaw_type    flaw;
      logic [31:0] base;
      r = $urandom_range(0, 99);
      if (r < 10) len = 0;
      else if (r < 80) len = $urandom_range(1, 8);
      else if (r < 97) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      r = $urandom_range(0, 99);
      flaw = (r < 85) ? FLAW_NONE : (r < 93) ? FLAW_ADDR_T : FLAW_ODD;
      // mostly aim near the region edges, else anywhere, so the range check sees both outcomes
      case ($urandom_range(0, 4))
         0: base = region_lo + $urandom_range(0, 64);
         1: base = region_hi - len - 1 + $urandom_range(0, 2);
         2: base = region_lo - $urandom_range(0, 2);
         default: base = $urandom();
      endcase
      send_frame(base, len, flaw);
   endtask

   // drop valid and let every outstanding result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input ahfr_pkg::reg_idx_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_region();
      logic [31:0] rd;
      csr_access(1'b0, ahfr_pkg::REG_PROG_START, '0, rd);
      if (rd !== region_lo) begin
         errors++;
         $display("%0t: prog_start read expected %h actual %h", $time, region_lo, rd);
      end
      csr_access(1'b0, ahfr_pkg::REG_PROG_END, '0, rd);
      if (rd !== region_hi) begin
         errors++;
         $display("%0t: prog_end read expected %h actual %h", $time, region_hi, rd);
      end
   endtask

   task automatic set_region(input logic [31:0] lo, input logic [31:0] hi);
      logic [31:0] rd;
      csr_access(1'b1, ahfr_pkg::REG_PROG_START, lo, rd);
      csr_access(1'b1, ahfr_pkg::REG_PROG_END, hi, rd);
      region_lo = lo;
      region_hi = hi;
      region_sets++;
      check_region();
   endtask

   task automatic row(input logic [7:0] ch, input bit typed, input ahfr_pkg::rsp_type want);
      script_row_type s;
      s.ch = ch;
      s.typed = typed;
      s.want = want;
      script_q.push_back(s);
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
      end
   endtask

   initial begin
      int run, hold;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 250) : $urandom_range(1, 8);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         if (!flood_done && results_seen >= 300) begin
            // hold off long enough to back the block up into its input
            hold = 400;
            flood_done = 1'b1;
         end else begin
            hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(1, 3);
         end
         rsp_stall <= 1'b1;
         repeat (hold) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      ahfr_pkg::rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         case (rsp_event_res)
            ahfr_pkg::EV_OK: begin
               frames_acked++;
               if (rsp_range_ok === 1'b1) acked_inside++;
            end
            ahfr_pkg::EV_ERR: frames_bad++;
            ahfr_pkg::EV_BOOT: boot_seen++;
            default: ;
         endcase
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with no word pending, event %0d", $time, rsp_event_res);
         end else begin
            want = pending_results.pop_front();
            check_field("event_res", 32'(want.event_res), 32'(rsp_event_res));
            check_field("reply_byte", 32'(want.reply_byte), 32'(rsp_reply_byte));
            check_field("data_byte", 32'(want.data_byte), 32'(rsp_data_byte));
            check_field("byte_index", 32'(want.byte_index), 32'(rsp_byte_index));
            check_field("block_address", want.block_address, rsp_block_address);
            check_field("block_length", 32'(want.block_length), 32'(rsp_block_length));
            check_field("range_ok", 32'(want.range_ok), 32'(rsp_range_ok));
         end
      end
   end

   initial begin
      int goal;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_region();

      row(ahfr_pkg::CHAR_NONE, 1'b1,
          outcome(ahfr_pkg::EV_NONE, ahfr_pkg::CHAR_NONE, '0, '0, 1'b0));
      row(ahfr_pkg::CHAR_Q, 1'b1,
          outcome(ahfr_pkg::EV_BOOT, ahfr_pkg::CHAR_NONE, '0, '0, 1'b0));
      row(ahfr_pkg::CHAR_S, 1'b1,
          outcome(ahfr_pkg::EV_START, ahfr_pkg::CHAR_NONE, '0, '0, 1'b0));
      row(ahfr_pkg::CHAR_T, 1'b1,
          outcome(ahfr_pkg::EV_ERR, ahfr_pkg::CHAR_X, '0, '0, 1'b0));
      row(ahfr_pkg::CHAR_S, 1'b1,
          outcome(ahfr_pkg::EV_START, ahfr_pkg::CHAR_NONE, '0, '0, 1'b0));
      // mixed case, then an 'S' and a top byte that both read as zero
      row(ahfr_pkg::CHAR_LF, 1'b0, '0);
      row(ahfr_pkg::CHAR_UF, 1'b0, '0);
      row(ahfr_pkg::CHAR_0, 1'b0, '0);
      row(ahfr_pkg::CHAR_9, 1'b0, '0);
      row(ahfr_pkg::CHAR_LA, 1'b0, '0);
      row(ahfr_pkg::CHAR_UA, 1'b0, '0);
      row(ahfr_pkg::CHAR_S, 1'b0, '0);
      row(8'hFF, 1'b1,
          outcome(ahfr_pkg::EV_ADDR, ahfr_pkg::CHAR_NONE, 32'hFF09_AA00, '0, 1'b0));
      row(ahfr_pkg::CHAR_9, 1'b0, '0);
      row(ahfr_pkg::CHAR_LF, 1'b0, '0);
      row(ahfr_pkg::CHAR_T, 1'b1,
          outcome(ahfr_pkg::EV_OK, ahfr_pkg::CHAR_K, 32'hFF09_AA00, 11'd1, 1'b0));
      row(ahfr_pkg::CHAR_S, 1'b1,
          outcome(ahfr_pkg::EV_START, ahfr_pkg::CHAR_NONE, '0, '0, 1'b0));
      for (int i = 0; i < ahfr_pkg::ADDR_NIBBLES; i++)
         row(i[0] ? CHAR_LZ : CHAR_UZ, 1'b0, '0);
      row(ahfr_pkg::CHAR_UA, 1'b0, '0);
      row(ahfr_pkg::CHAR_T, 1'b1,
          outcome(ahfr_pkg::EV_ERR, ahfr_pkg::CHAR_X, '0, '0, 1'b0));
      foreach (script_q[i]) send_word(script_q[i].ch, script_q[i].typed, script_q[i].want);

      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         case (ph)
            1: set_region(32'h0000_0000, 32'hFFFF_FFFF);
            2: set_region(32'hFFFF_FFFF, 32'h0000_0000);
            3: set_region(32'h0000_2000, 32'h0000_2000);
            4: begin
               goal = $urandom();
               set_region(goal, goal + $urandom_range(16, 4096));
            end
            5: set_region(32'h7FFF_FFF0, 32'h8000_0010);
            default: ;
         endcase
         goal = words_sent + PHASE_WORDS;
         while (words_sent < goal) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 4))
                  send_char(($urandom_range(0, 3) == 0) ? ahfr_pkg::CHAR_Q
                                                        : 8'($urandom_range(0, 255)));
            end
            send_random_frame();
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, pending_results.size());
      end
      $display("Sent %0d words, checked %0d results: %0d frames acked (%0d in region),",
               words_sent, results_seen, frames_acked, acked_inside);
      $display("%0d rejected, %0d boot; region rewritten %0d times incl. full, reversed, empty",
               frames_bad, boot_seen, region_sets);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ahfr_pkg.sv
rtl/ahfr_csr.sv
rtl/ahfr_parser.sv
rtl/ahfr_skid.sv
rtl/ascii_hex_frame_receiver_core.sv
rtl/ahfr_checker.sv
bench/ascii_hex_frame_receiver_core_test.sv
